### src/ssg_pkg.sv
// ----------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants for the scan sector collision gate.
// ----------------------------------------------------------------------------
package ssg_pkg;

    localparam int SECTOR_COUNT       = 5;
    localparam int MAX_SECTOR_LEN_DEF = 256;
    localparam int IDX_W              = 11;
    localparam int CFG_IDX_W          = 3;
    localparam int CFG_DATA_W         = 16;
    localparam int QUEUE_DEPTH        = 2;

    localparam logic [IDX_W-1:0] INDEX_MAX = {IDX_W{1'b1}};
    localparam logic [15:0]      RANGE_MAX = 16'hFFFF;

    localparam logic [CFG_IDX_W-1:0] CFG_SECTOR_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR_THRESH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MANUAL_MODE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ASSIST_ENABLE = 3'd3;

    localparam int SEC_RIGHT       = 0;
    localparam int SEC_FRONT_RIGHT = 1;
    localparam int SEC_FRONT       = 2;
    localparam int SEC_FRONT_LEFT  = 3;
    localparam int SEC_LEFT        = 4;

    localparam int RULE_FRONT       = 0;
    localparam int RULE_FRONT_LEFT  = 1;
    localparam int RULE_FRONT_RIGHT = 2;
    localparam int RULE_LEFT        = 3;
    localparam int RULE_RIGHT       = 4;

    localparam logic KIND_VELOCITY = 1'b0;
    localparam logic KIND_SAMPLE   = 1'b1;

    typedef struct packed {
        logic               kind;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
        logic        [15:0] range_mm;
        logic               last_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] out_linear;
        logic signed [15:0] out_angular;
        logic        [4:0]  rules_fired;
    } t_out_item;

    typedef struct packed {
        logic [8:0]  sector_length;
        logic [15:0] near_threshold_mm;
        logic        manual_mode;
        logic        assist_enable;
    } t_cfg;

    typedef enum logic [1:0] {
        OP_PASS = 2'd0,
        OP_HOLD = 2'd1,
        OP_SCAN = 2'd2
    } t_op_kind;

    typedef struct packed {
        t_op_kind                  kind;
        logic signed [15:0]        lin;
        logic signed [15:0]        ang;
        logic [SECTOR_COUNT-1:0]   near;
    } t_op;

endpackage

### src/ssg_fifo.sv
// ----------------------------------------------------------------------------
// ssg_fifo
// Small register queue with first-word fall-through read.
// ----------------------------------------------------------------------------
module ssg_fifo #(
    parameter type T     = logic,
    parameter int  DEPTH = ssg_pkg::QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  T     i_data,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output T     o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    T                 r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_cnt;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == LAST_PTR) ? '0 : r_wr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == LAST_PTR) ? '0 : r_rd + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

### src/ssg_front.sv
// ----------------------------------------------------------------------------
// ssg_front
// Classifies items, tracks sector minima and issues operations to the back.
// ----------------------------------------------------------------------------
module ssg_front #(
    parameter int MAX_SECTOR_LEN = ssg_pkg::MAX_SECTOR_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ssg_pkg::t_cfg     i_cfg,
    input  logic              i_accept,
    input  ssg_pkg::t_in_item i_item,
    output logic              o_op_push,
    output ssg_pkg::t_op      o_op
);

    localparam int IW  = ssg_pkg::IDX_W;
    localparam int PW  = IW + 3;
    localparam int NS  = ssg_pkg::SECTOR_COUNT;
    localparam logic [IW-1:0] MAX_LEN = IW'(MAX_SECTOR_LEN);

    logic [15:0]   r_min [NS];
    logic [IW-1:0] r_idx;
    logic [15:0]   n_min [NS];
    logic [IW-1:0] n_idx;

    logic [IW-1:0] cfg_len;
    logic [IW-1:0] len;
    logic [PW-1:0] bound [NS];
    logic          in_scan;
    logic [2:0]    sector;
    logic [15:0]   upd_min [NS];
    logic [NS-1:0] near;
    logic          is_sample;

    assign cfg_len   = IW'(i_cfg.sector_length);
    assign len       = (cfg_len > MAX_LEN) ? MAX_LEN : cfg_len;
    assign is_sample = (i_item.kind == ssg_pkg::KIND_SAMPLE);

    always_comb begin
        sector = '0;
        for (int k = 0; k < NS; k++) begin
            bound[k] = PW'(len) * PW'(k + 1);
        end
        for (int k = 0; k < NS - 1; k++) begin
            if (PW'(r_idx) >= bound[k]) begin
                sector = sector + 3'd1;
            end
        end
        in_scan = (len != '0) && (PW'(r_idx) < bound[NS-1]);
        for (int s = 0; s < NS; s++) begin
            upd_min[s] = r_min[s];
            if (in_scan && (sector == 3'(s)) && (i_item.range_mm < r_min[s])) begin
                upd_min[s] = i_item.range_mm;
            end
            near[s] = (upd_min[s] < i_cfg.near_threshold_mm);
        end
    end

    always_comb begin
        for (int s = 0; s < NS; s++) begin
            n_min[s] = r_min[s];
        end
        n_idx = r_idx;
        if (i_accept && is_sample) begin
            for (int s = 0; s < NS; s++) begin
                n_min[s] = i_item.last_sample ? ssg_pkg::RANGE_MAX : upd_min[s];
            end
            if (i_item.last_sample) begin
                n_idx = '0;
            end else if (r_idx != ssg_pkg::INDEX_MAX) begin
                n_idx = r_idx + IW'(1);
            end
        end
    end

    always_comb begin
        o_op.lin  = i_item.linear_speed;
        o_op.ang  = i_item.angular_speed;
        o_op.near = near;
        o_op_push = 1'b0;
        if (is_sample) begin
            o_op.kind = ssg_pkg::OP_SCAN;
            o_op_push = i_accept && i_item.last_sample && i_cfg.assist_enable;
        end else begin
            o_op.kind = i_cfg.assist_enable ? ssg_pkg::OP_HOLD : ssg_pkg::OP_PASS;
            o_op_push = i_accept && i_cfg.manual_mode;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NS; s++) begin
                r_min[s] <= ssg_pkg::RANGE_MAX;
            end
            r_idx <= '0;
        end else begin
            for (int s = 0; s < NS; s++) begin
                r_min[s] <= n_min[s];
            end
            r_idx <= n_idx;
        end
    end

endmodule

### src/ssg_back.sv
// ----------------------------------------------------------------------------
// ssg_back
// Holds the command, applies the wall rules at scan end and emits results.
// ----------------------------------------------------------------------------
module ssg_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_op_empty,
    input  ssg_pkg::t_op       i_op,
    output logic               o_op_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output ssg_pkg::t_out_item o_res
);

    logic signed [15:0] r_held_lin;
    logic signed [15:0] r_held_ang;
    logic signed [15:0] n_held_lin;
    logic signed [15:0] n_held_ang;
    logic signed [15:0] lin;
    logic signed [15:0] ang;
    logic [4:0]         fired;
    logic               needs_out;

    always_comb begin
        lin   = r_held_lin;
        ang   = r_held_ang;
        fired = '0;
        if (i_op.near[ssg_pkg::SEC_FRONT] && lin > 0 && ang == 0) begin
            lin = '0;
            fired[ssg_pkg::RULE_FRONT] = 1'b1;
        end
        if (i_op.near[ssg_pkg::SEC_FRONT_LEFT] && lin > 0 && ang > 0) begin
            lin = '0;
            ang = '0;
            fired[ssg_pkg::RULE_FRONT_LEFT] = 1'b1;
        end
        if (i_op.near[ssg_pkg::SEC_FRONT_RIGHT] && lin > 0 && ang < 0) begin
            lin = '0;
            ang = '0;
            fired[ssg_pkg::RULE_FRONT_RIGHT] = 1'b1;
        end
        if (i_op.near[ssg_pkg::SEC_LEFT] && lin == 0 && ang > 0) begin
            ang = '0;
            fired[ssg_pkg::RULE_LEFT] = 1'b1;
        end
        if (i_op.near[ssg_pkg::SEC_RIGHT] && lin == 0 && ang < 0) begin
            ang = '0;
            fired[ssg_pkg::RULE_RIGHT] = 1'b1;
        end
    end

    always_comb begin
        n_held_lin = r_held_lin;
        n_held_ang = r_held_ang;
        o_res      = '{out_linear: i_op.lin, out_angular: i_op.ang, rules_fired: 5'd0};
        needs_out  = 1'b0;
        case (i_op.kind)
            ssg_pkg::OP_PASS: begin
                needs_out = 1'b1;
            end
            ssg_pkg::OP_HOLD: begin
                n_held_lin = i_op.lin;
                n_held_ang = i_op.ang;
            end
            ssg_pkg::OP_SCAN: begin
                needs_out  = 1'b1;
                n_held_lin = lin;
                n_held_ang = ang;
                o_res      = '{out_linear: lin, out_angular: ang, rules_fired: fired};
            end
            default: begin
                needs_out = 1'b0;
            end
        endcase
        o_op_pop   = !i_op_empty && (!needs_out || !i_res_full);
        o_res_push = o_op_pop && needs_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_lin <= '0;
            r_held_ang <= '0;
        end else if (o_op_pop) begin
            r_held_lin <= n_held_lin;
            r_held_ang <= n_held_ang;
        end
    end

endmodule

### src/scan_sector_collision_gate.sv
// ----------------------------------------------------------------------------
// scan_sector_collision_gate
// Gates velocity commands against the closest wall in five scan sectors.
//
//   channel   direction  handshake              payload
//   items     in         push / full            i_item   (t_in_item)
//   results   out        empty / pop            o_result (t_out_item)
//   config    in         i_cfg_valid / o_cfg_ready  index, data
//
// One item per cycle while full is low; the result that an item causes passes
// through the operation queue and then the result queue to the output.
// The rate is set by the combinational sector compare in the front and the
// combinational rule pass in the back.
// Synchronous active-low reset empties both queues, restores the minima and
// the held command; no clearing pass is needed.
// full rises when the operation queue is full; a stalled output backs up into it.
// ----------------------------------------------------------------------------
module scan_sector_collision_gate #(
    parameter int MAX_SECTOR_LEN = ssg_pkg::MAX_SECTOR_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  ssg_pkg::t_in_item                  i_item,
    output logic                               empty,
    input  logic                               pop,
    output ssg_pkg::t_out_item                 o_result,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [ssg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [ssg_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    ssg_pkg::t_cfg      r_cfg;
    logic               accept;
    logic               op_push;
    ssg_pkg::t_op       op_in;
    logic               op_full;
    logic               op_pop;
    logic               op_empty;
    ssg_pkg::t_op       op_head;
    logic               res_push;
    logic               res_full;
    ssg_pkg::t_out_item res_in;

    assign o_cfg_ready = 1'b1;
    assign full        = op_full;
    assign accept      = push && !op_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{sector_length: 9'd144, near_threshold_mm: 16'd500,
                       manual_mode: 1'b0, assist_enable: 1'b0};
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                ssg_pkg::CFG_SECTOR_LENGTH: r_cfg.sector_length     <= i_cfg_data[8:0];
                ssg_pkg::CFG_NEAR_THRESH:   r_cfg.near_threshold_mm <= i_cfg_data;
                ssg_pkg::CFG_MANUAL_MODE:   r_cfg.manual_mode       <= i_cfg_data[0];
                ssg_pkg::CFG_ASSIST_ENABLE: r_cfg.assist_enable     <= i_cfg_data[0];
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    ssg_front #(
        .MAX_SECTOR_LEN(MAX_SECTOR_LEN)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_accept  (accept),
        .i_item    (i_item),
        .o_op_push (op_push),
        .o_op      (op_in)
    );

    ssg_fifo #(
        .T     (ssg_pkg::t_op),
        .DEPTH (ssg_pkg::QUEUE_DEPTH)
    ) u_op_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (op_push),
        .i_data  (op_in),
        .o_full  (op_full),
        .i_pop   (op_pop),
        .o_empty (op_empty),
        .o_data  (op_head)
    );

    ssg_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_empty (op_empty),
        .i_op       (op_head),
        .o_op_pop   (op_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    ssg_fifo #(
        .T     (ssg_pkg::t_out_item),
        .DEPTH (ssg_pkg::QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res_in),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (o_result)
    );

endmodule

### src/ssg_checker.sv
// ----------------------------------------------------------------------------
// ssg_checker
// Port-level checks on results of the collision gate.
// ----------------------------------------------------------------------------
module ssg_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           empty,
    input logic                           pop,
    input ssg_pkg::t_out_item             o_result
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> $stable(o_result))
        else $error("waiting result changed before transfer");

    a_lin_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.rules_fired[0] || o_result.rules_fired[1]
                    || o_result.rules_fired[2])) |-> (o_result.out_linear == 0))
        else $error("forward rule fired but linear speed not zero");

    a_ang_zeroed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_result.rules_fired[1] || o_result.rules_fired[2]
                    || o_result.rules_fired[3] || o_result.rules_fired[4]))
        |-> (o_result.out_angular == 0))
        else $error("turn rule fired but angular speed not zero");

    a_rules_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ($onehot0(o_result.rules_fired[2:0])
                    && $onehot0(o_result.rules_fired[4:3])))
        else $error("mutually exclusive rules fired together");

endmodule

bind scan_sector_collision_gate ssg_checker u_ssg_checker (.*);

### tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the scan sector collision gate. A clocked driver
// offers items from a backlog in bursts, a clocked monitor pops results on a
// changing stall pattern and checks each one against a local model of the
// sector minima, the held command and the five gating rules. Configuration
// is rewritten between phases once the gate has drained.
// ----------------------------------------------------------------------------
module tb_top;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_LIGHT,
        RX_HEAVY,
        RX_PERIODIC
    } t_rx_mode;

    logic                           i_clk       = 1'b0;
    logic                           i_rst_n     = 1'b0;
    logic                           push        = 1'b0;
    logic                           full;
    ssg_pkg::t_in_item              i_item      = '0;
    logic                           empty;
    logic                           pop         = 1'b0;
    ssg_pkg::t_out_item             o_result;
    logic                           i_cfg_valid = 1'b0;
    logic                           o_cfg_ready;
    logic [ssg_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [ssg_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    scan_sector_collision_gate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // model of the gate
    logic [8:0]                gate_len    = 9'd144;
    logic [15:0]               gate_thr    = 16'd500;
    logic                      gate_manual = 1'b0;
    logic                      gate_assist = 1'b0;
    logic [15:0]               sec_min [ssg_pkg::SECTOR_COUNT];
    logic [ssg_pkg::IDX_W-1:0] scan_idx;
    logic signed [15:0]        held_lin    = '0;
    logic signed [15:0]        held_ang    = '0;

    ssg_pkg::t_in_item  offer_items [$];
    ssg_pkg::t_out_item due_cmds [$];
    int                 fail_count = 0;
    int                 hold_seq   = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #4800000;
        $display("** scan_sector_collision_gate: FAILED **");
        $finish;
    end

    task automatic clear_scan();
        for (int i = 0; i < ssg_pkg::SECTOR_COUNT; i++) sec_min[i] = ssg_pkg::RANGE_MAX;
        scan_idx = '0;
    endtask

    task automatic gate_step(input ssg_pkg::t_in_item it);
        int                 eff_len;
        int                 sector;
        int                 lin;
        int                 ang;
        logic [4:0]         fired;
        ssg_pkg::t_out_item res;
        if (it.kind == ssg_pkg::KIND_VELOCITY) begin
            if (!gate_manual) return;
            if (!gate_assist) begin
                res.out_linear  = it.linear_speed;
                res.out_angular = it.angular_speed;
                res.rules_fired = '0;
                due_cmds.push_back(res);
                return;
            end
            held_lin = it.linear_speed;
            held_ang = it.angular_speed;
            return;
        end
        eff_len = (gate_len > ssg_pkg::MAX_SECTOR_LEN_DEF) ? ssg_pkg::MAX_SECTOR_LEN_DEF
                                                           : gate_len;
        if (eff_len != 0) begin
            sector = scan_idx / eff_len;
            if (sector < ssg_pkg::SECTOR_COUNT && it.range_mm < sec_min[sector])
                sec_min[sector] = it.range_mm;
        end
        if (scan_idx != ssg_pkg::INDEX_MAX) scan_idx = scan_idx + 1'b1;
        if (!it.last_sample) return;
        if (!gate_assist) begin
            clear_scan();
            return;
        end
        lin   = held_lin;
        ang   = held_ang;
        fired = '0;
        if (sec_min[ssg_pkg::SEC_FRONT] < gate_thr && lin > 0 && ang == 0) begin
            lin = 0;
            fired[ssg_pkg::RULE_FRONT] = 1'b1;
        end
        if (sec_min[ssg_pkg::SEC_FRONT_LEFT] < gate_thr && lin > 0 && ang > 0) begin
            lin = 0;
            ang = 0;
            fired[ssg_pkg::RULE_FRONT_LEFT] = 1'b1;
        end
        if (sec_min[ssg_pkg::SEC_FRONT_RIGHT] < gate_thr && lin > 0 && ang < 0) begin
            lin = 0;
            ang = 0;
            fired[ssg_pkg::RULE_FRONT_RIGHT] = 1'b1;
        end
        if (sec_min[ssg_pkg::SEC_LEFT] < gate_thr && lin == 0 && ang > 0) begin
            ang = 0;
            fired[ssg_pkg::RULE_LEFT] = 1'b1;
        end
        if (sec_min[ssg_pkg::SEC_RIGHT] < gate_thr && lin == 0 && ang < 0) begin
            ang = 0;
            fired[ssg_pkg::RULE_RIGHT] = 1'b1;
        end
        held_lin = lin[15:0];
        held_ang = ang[15:0];
        clear_scan();
        res.out_linear  = held_lin;
        res.out_angular = held_ang;
        res.rules_fired = fired;
        due_cmds.push_back(res);
    endtask

    // ---- stimulus helpers ----
    function automatic logic [15:0] rnd16(int unsigned lo, int unsigned hi);
        logic [31:0] r;
        r = $urandom_range(hi, lo);
        return r[15:0];
    endfunction

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(9, 0))
            0, 1:    return 16'h0000;
            2:       return 16'h7FFF;
            3:       return 16'h8000;
            4:       return 16'h0001;
            5:       return 16'hFFFF;
            6, 7:    return rnd16(1, 32767);
            8:       return rnd16(32768, 65535);
            default: return rnd16(0, 65535);
        endcase
    endfunction

    function automatic logic [15:0] pick_range(logic [15:0] thr);
        int          t;
        int          v;
        int          jit;
        logic [31:0] b;
        t   = thr;
        jit = $urandom_range(40, 0);
        case ($urandom_range(7, 0))
            0:       v = 65535;
            1:       v = 0;
            2:       v = t - 1;
            3:       v = t;
            4:       v = t + 1;
            5, 6:    v = $urandom_range(65535, 0);
            default: v = t + jit - 20;
        endcase
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
        b = v;
        return b[15:0];
    endfunction

    function automatic ssg_pkg::t_in_item mk_cmd(logic [15:0] lin, logic [15:0] ang);
        ssg_pkg::t_in_item it;
        logic [31:0]       r;
        r                = $urandom;
        it.kind          = ssg_pkg::KIND_VELOCITY;
        it.linear_speed  = lin;
        it.angular_speed = ang;
        it.range_mm      = r[15:0];
        it.last_sample   = r[16];
        return it;
    endfunction

    function automatic ssg_pkg::t_in_item mk_sample(logic [15:0] range, logic last);
        ssg_pkg::t_in_item it;
        logic [31:0]       r;
        r                = $urandom;
        it.kind          = ssg_pkg::KIND_SAMPLE;
        it.linear_speed  = r[15:0];
        it.angular_speed = r[31:16];
        it.range_mm      = range;
        it.last_sample   = last;
        return it;
    endfunction

    // sparse: percentage of samples that see nothing at all
    task automatic add_scan(int n, int sparse);
        logic [15:0] range;
        for (int k = 0; k < n; k++) begin
            range = ($urandom_range(99, 0) < sparse) ? ssg_pkg::RANGE_MAX
                                                     : pick_range(gate_thr);
            offer_items.push_back(mk_sample(range, k == n - 1));
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk); while (offer_items.size() != 0 || due_cmds.size() != 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [ssg_pkg::CFG_IDX_W-1:0] idx,
                             logic [ssg_pkg::CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            ssg_pkg::CFG_SECTOR_LENGTH: gate_len    = data[8:0];
            ssg_pkg::CFG_NEAR_THRESH:   gate_thr    = data;
            ssg_pkg::CFG_MANUAL_MODE:   gate_manual = data[0];
            ssg_pkg::CFG_ASSIST_ENABLE: gate_assist = data[0];
            default: ;
        endcase
    endtask

    task automatic set_gate_cfg(logic [8:0] len, logic [15:0] thr, logic man, logic ast);
        wait_drained();
        write_reg(ssg_pkg::CFG_SECTOR_LENGTH, {7'd0, len});
        write_reg(ssg_pkg::CFG_NEAR_THRESH, thr);
        write_reg(ssg_pkg::CFG_MANUAL_MODE, {15'd0, man});
        write_reg(ssg_pkg::CFG_ASSIST_ENABLE, {15'd0, ast});
        @(negedge i_clk);
    endtask

    task automatic run_phase(int n);
        int                made;
        int                eff;
        int                scan_n;
        logic [31:0]       r1;
        logic [31:0]       r2;
        ssg_pkg::t_in_item it;
        made = 0;
        eff  = (gate_len > ssg_pkg::MAX_SECTOR_LEN_DEF) ? ssg_pkg::MAX_SECTOR_LEN_DEF
                                                        : gate_len;
        while (made < n) begin
            if ($urandom_range(9, 0) < 7) begin
                offer_items.push_back(mk_cmd(pick_speed(), pick_speed()));
                if (gate_manual) made++;
                scan_n = (eff == 0) ? $urandom_range(8, 1) : 5 * eff + $urandom_range(2, 0);
                if ($urandom_range(4, 0) == 0) scan_n = $urandom_range(scan_n, 1);
                add_scan(scan_n, $urandom_range(95, 0));
                made += scan_n;
            end else begin
                r1               = $urandom;
                r2               = $urandom;
                it.kind          = r1[0];
                it.linear_speed  = r1[31:16];
                it.angular_speed = r2[15:0];
                it.range_mm      = r2[31:16];
                it.last_sample   = ($urandom_range(7, 0) == 0);
                offer_items.push_back(it);
                if (it.kind == ssg_pkg::KIND_SAMPLE || gate_manual) made++;
            end
        end
    endtask

    // ---- driver: bursts of transfers with gaps between ----
    int                burst_left = 0;
    int                gap_left   = 0;
    ssg_pkg::t_in_item sent_item;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                sent_item = offer_items.pop_front();
                gate_step(sent_item);
            end
            if (gap_left != 0) begin
                gap_left--;
                push <= 1'b0;
            end else if (offer_items.size() != 0) begin
                push   <= 1'b1;
                i_item <= offer_items[0];
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = ($urandom_range(7, 0) == 0) ? $urandom_range(250, 80)
                                                             : $urandom_range(30, 1);
                    gap_left   = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(12, 1);
                end
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ---- monitor: pops on its own stall pattern and checks ----
    t_rx_mode           rx_mode      = RX_STEADY;
    int                 rx_mode_left = 0;
    int                 rx_tick      = 0;
    int                 hold_left    = 0;
    int                 hold_seen    = 0;
    ssg_pkg::t_out_item want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (due_cmds.size() == 0) begin
                    $error("result with none due: out_linear %0d out_angular %0d rules_fired %b",
                           o_result.out_linear, o_result.out_angular, o_result.rules_fired);
                    fail_count++;
                end else begin
                    want = due_cmds.pop_front();
                    if (o_result.out_linear !== want.out_linear) begin
                        $error("out_linear: expected %0d, got %0d",
                               want.out_linear, o_result.out_linear);
                        fail_count++;
                    end
                    if (o_result.out_angular !== want.out_angular) begin
                        $error("out_angular: expected %0d, got %0d",
                               want.out_angular, o_result.out_angular);
                        fail_count++;
                    end
                    if (o_result.rules_fired !== want.rules_fired) begin
                        $error("rules_fired: expected %b, got %b",
                               want.rules_fired, o_result.rules_fired);
                        fail_count++;
                    end
                end
            end
            if (hold_seen != hold_seq) begin
                hold_seen = hold_seq;
                hold_left = 300;
            end
            if (hold_left != 0) begin
                hold_left--;
                pop <= 1'b0;
            end else begin
                if (rx_mode_left == 0) begin
                    rx_mode      = t_rx_mode'($urandom_range(3, 0));
                    rx_mode_left = $urandom_range(120, 20);
                end else begin
                    rx_mode_left--;
                end
                rx_tick++;
                case (rx_mode)
                    RX_STEADY: pop <= 1'b1;
                    RX_LIGHT:  pop <= ($urandom_range(99, 0) >= 25);
                    RX_HEAVY:  pop <= ($urandom_range(99, 0) >= 75);
                    default:   pop <= (rx_tick % 3 == 0);
                endcase
            end
        end
    end

    // ---- sequence ----
    initial begin
        logic [8:0]  len_v;
        logic [15:0] thr_v;
        logic        man_v;
        logic        ast_v;
        logic [31:0] r;
        clear_scan();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // defaults: command dropped, scan end with assist off
        offer_items.push_back(mk_cmd(16'h0100, 16'h0000));
        offer_items.push_back(mk_sample(16'h0000, 1'b1));

        // pass-through at the speed extremes
        set_gate_cfg(9'd1, 16'hFFFF, 1'b1, 1'b0);
        offer_items.push_back(mk_cmd(16'h7FFF, 16'h8000));
        offer_items.push_back(mk_cmd(16'h8000, 16'h7FFF));
        offer_items.push_back(mk_cmd(16'h0000, 16'h0000));
        offer_items.push_back(mk_cmd(16'hFFFF, 16'h0001));

        // one scan per rule, then a scan end with nothing new held
        set_gate_cfg(9'd1, 16'hFFFF, 1'b1, 1'b1);
        offer_items.push_back(mk_cmd(16'h0100, 16'h0000));
        offer_items.push_back(mk_sample(16'hFFFF, 1'b0));
        offer_items.push_back(mk_sample(16'hFFFF, 1'b0));
        offer_items.push_back(mk_sample(16'h0000, 1'b1));
        offer_items.push_back(mk_cmd(16'h0100, 16'h0064));
        for (int k = 0; k < 3; k++) offer_items.push_back(mk_sample(16'hFFFF, 1'b0));
        offer_items.push_back(mk_sample(16'hFFFE, 1'b1));
        offer_items.push_back(mk_cmd(16'h0000, 16'h0064));
        for (int k = 0; k < 4; k++) offer_items.push_back(mk_sample(16'hFFFF, 1'b0));
        offer_items.push_back(mk_sample(16'h0000, 1'b1));
        offer_items.push_back(mk_cmd(16'h0000, 16'hFF9C));
        offer_items.push_back(mk_sample(16'h0000, 1'b1));
        offer_items.push_back(mk_cmd(16'h0100, 16'hFF9C));
        offer_items.push_back(mk_sample(16'hFFFF, 1'b0));
        offer_items.push_back(mk_sample(16'h0000, 1'b1));
        offer_items.push_back(mk_sample(16'hFFFF, 1'b1));

        // receiver holds off while commands keep coming, so the gate backs up
        set_gate_cfg(9'd4, 16'd500, 1'b1, 1'b0);
        hold_seq++;
        for (int k = 0; k < 150; k++) offer_items.push_back(mk_cmd(pick_speed(), pick_speed()));

        for (int ph = 0; ph < 8; ph++) begin
            case ($urandom_range(9, 0))
                0:       len_v = 9'd0;
                1:       len_v = 9'd1;
                2:       len_v = 9'd2;
                9:       begin r = $urandom_range(40, 11); len_v = r[8:0]; end
                default: begin r = $urandom_range(10, 3); len_v = r[8:0]; end
            endcase
            if (ph == 0) len_v = 9'd0;
            if (ph == 1) len_v = 9'd1;
            case ($urandom_range(4, 0))
                0:       thr_v = 16'd0;
                1:       thr_v = 16'hFFFF;
                2:       thr_v = 16'd500;
                default: thr_v = rnd16(0, 65535);
            endcase
            if (ph == 2) thr_v = 16'd0;
            if (ph == 3) thr_v = 16'hFFFF;
            man_v = (ph == 4 || ph == 5) ? 1'b0 : ($urandom_range(4, 0) != 0);
            ast_v = (ph == 6) ? 1'b0 : ($urandom_range(4, 0) != 0);
            set_gate_cfg(len_v, thr_v, man_v, ast_v);
            run_phase(100);
        end

        // a length above the cap: samples past the capped sector width move on
        set_gate_cfg(9'd511, 16'd500, 1'b1, 1'b1);
        offer_items.push_back(mk_cmd(16'h0100, 16'h0000));
        add_scan(2 * ssg_pkg::MAX_SECTOR_LEN_DEF + 40, 50);

        wait_drained();
        if (fail_count == 0) begin
            $display("** scan_sector_collision_gate: PASSED **");
        end else begin
            $display("** scan_sector_collision_gate: FAILED **");
        end
        $finish;
    end

endmodule
